### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int ID_WIDTH   = 16;
  localparam int PRIO_WIDTH = 8;
  localparam int OCC_WIDTH  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // input word
  typedef struct packed {
    action_t               action;
    logic [ID_WIDTH-1:0]   entry_id;
    logic [PRIO_WIDTH-1:0] entry_priority;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t               status;
    logic [ID_WIDTH-1:0]   removed_id;
    logic [PRIO_WIDTH-1:0] removed_priority;
    logic [OCC_WIDTH-1:0]  occupancy;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_APPLY = 2'd2
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accept a word, compare all slots, then apply the update.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output spq_pkg::cmd_t    cmd
);
  import spq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Slot array kept in descending priority order, compare masks and result.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spq_pkg::cmd_t     cmd,
  input  wire spq_pkg::in_word_t in_word,
  output logic                   out_valid,
  output spq_pkg::out_word_t     out_word
);
  import spq_pkg::*;

  in_word_t              req_r;
  logic [ID_WIDTH-1:0]   slot_id_r   [CAPACITY];
  logic [PRIO_WIDTH-1:0] slot_prio_r [CAPACITY];
  logic [ID_WIDTH-1:0]   slot_id_nxt   [CAPACITY];
  logic [PRIO_WIDTH-1:0] slot_prio_nxt [CAPACITY];
  logic [OCC_WIDTH-1:0]  count_r, count_nxt;
  logic [CAPACITY-1:0]   ge_r, ge_nxt;    // held slots with priority >= new one
  logic [CAPACITY-1:0]   hit_r, hit_nxt;  // held slots whose id matches
  logic                  out_valid_r;
  out_word_t             out_word_r, out_word_nxt;

  logic [CAPACITY-1:0]   first;
  logic [CAPACITY-1:0]   drop_from;
  logic                  empty, full, found, do_ins, do_drop;
  logic [ID_WIDTH-1:0]   sel_id;
  logic [PRIO_WIDTH-1:0] sel_prio;

  // compare stage: every slot in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_nxt[i]  = (OCC_WIDTH'(i) < count_r) && (slot_prio_r[i] >= req_r.entry_priority);
      hit_nxt[i] = (OCC_WIDTH'(i) < count_r) && (slot_id_r[i] == req_r.entry_id);
    end
  end

  // apply stage
  always_comb begin
    empty = (count_r == '0);
    full  = (count_r == OCC_WIDTH'(CAPACITY));
    // pop takes the head; remove takes the lowest matching slot
    if (req_r.action == ACT_POP) begin
      first = {{(CAPACITY-1){1'b0}}, 1'b1};
    end else begin
      first = hit_r & (~hit_r + CAPACITY'(1));
    end
    drop_from = ~(first - CAPACITY'(1));
    found     = |first;
    do_ins    = (req_r.action == ACT_INSERT) && !full;
    do_drop   = ((req_r.action == ACT_POP) || (req_r.action == ACT_REMOVE))
                && !empty && found;

    sel_id   = '0;
    sel_prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        sel_id   = sel_id | slot_id_r[i];
        sel_prio = sel_prio | slot_prio_r[i];
      end
    end

    // slot shifting: insert opens a gap, drop closes one
    for (int i = 0; i < CAPACITY; i++) begin
      slot_id_nxt[i]   = slot_id_r[i];
      slot_prio_nxt[i] = slot_prio_r[i];
    end
    if (do_ins) begin
      if (!ge_r[0]) begin
        slot_id_nxt[0]   = req_r.entry_id;
        slot_prio_nxt[0] = req_r.entry_priority;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!ge_r[i]) begin
          if (ge_r[i-1]) begin
            slot_id_nxt[i]   = req_r.entry_id;
            slot_prio_nxt[i] = req_r.entry_priority;
          end else begin
            slot_id_nxt[i]   = slot_id_r[i-1];
            slot_prio_nxt[i] = slot_prio_r[i-1];
          end
        end
      end
    end else if (do_drop) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (drop_from[i]) begin
          slot_id_nxt[i]   = slot_id_r[i+1];
          slot_prio_nxt[i] = slot_prio_r[i+1];
        end
      end
    end

    count_nxt = count_r;
    if (do_ins)       count_nxt = count_r + OCC_WIDTH'(1);
    else if (do_drop) count_nxt = count_r - OCC_WIDTH'(1);

    // result word
    out_word_nxt.status           = ST_OK;
    out_word_nxt.removed_id       = do_drop ? sel_id : '0;
    out_word_nxt.removed_priority = do_drop ? sel_prio : '0;
    out_word_nxt.occupancy        = count_nxt;
    case (req_r.action)
      ACT_INSERT: if (full) out_word_nxt.status = ST_FULL;
      ACT_POP:    if (empty) out_word_nxt.status = ST_EMPTY;
      ACT_REMOVE: begin
        if (empty)      out_word_nxt.status = ST_EMPTY;
        else if (!found) out_word_nxt.status = ST_NOT_FOUND;
      end
      default: out_word_nxt.status = ST_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.apply;
      if (cmd.apply) count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_word;
    if (cmd.eval) begin
      ge_r  <= ge_nxt;
      hit_r <= hit_nxt;
    end
    if (cmd.apply) begin
      out_word_r <= out_word_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_id_r[i]   <= slot_id_nxt[i];
        slot_prio_r[i] <= slot_prio_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Priority queue of (id, priority) entries in a sorted shifting slot array.
// ----------------------------------------------------------------------------
// Each operation runs as follows: a command word is taken on a rising edge with
// start high and busy low, all slots are compared in parallel in the next
// cycle, the slot array shifts in the cycle after, and the result word is
// shown on out_word for exactly one cycle with out_valid high. busy falls as
// the result appears, so a new word may be started in that cycle; no word is
// taken while busy is high. The result cannot be held off: a receiver must
// take it in the cycle that out_valid is high. No clearing pass follows reset.
`default_nettype none

module sorted_priority_task_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire spq_pkg::in_word_t in_word,
  output logic                   out_valid,
  output spq_pkg::out_word_t     out_word
);
  import spq_pkg::*;

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  spq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // checks
  a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid) else $error("apply without result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.occupancy <= OCC_WIDTH'(CAPACITY)))
    else $error("occupancy above capacity");

endmodule

`default_nettype wire

### bench/queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_checker
// Watches the command and result channels of the sorted priority task queue,
// keeps its own sorted copy of the queue and checks every result word.
// ----------------------------------------------------------------------------
module queue_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  spq_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  spq_pkg::out_word_t out_word,
  output int                 mismatches,
  output int                 outstanding,
  output int                 ok_seen,
  output int                 empty_seen,
  output int                 absent_seen,
  output int                 full_seen,
  output int                 peak_held
);
  import spq_pkg::*;

  // shadow copy of the slot array, head at index 0
  logic [ID_WIDTH-1:0]   shadow_id   [CAPACITY];
  logic [PRIO_WIDTH-1:0] shadow_prio [CAPACITY];
  int                    held;

  // results owed by the block, oldest first
  out_word_t             owed [$];
  out_word_t             due;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    ok_seen     = 0;
    empty_seen  = 0;
    absent_seen = 0;
    full_seen   = 0;
    peak_held   = 0;
    held        = 0;
  end

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  // close the gap left at slot pos
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < held; i++) begin
      shadow_id[i]   = shadow_id[i + 1];
      shadow_prio[i] = shadow_prio[i + 1];
    end
    held--;
  endfunction

  // apply one command to the shadow queue and return the word it should give
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    int        pos;
    int        hit;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind everything of equal or higher priority
          pos = 0;
          while (pos < held && shadow_prio[pos] >= w.entry_priority) pos++;
          for (int i = held; i > pos; i--) begin
            shadow_id[i]   = shadow_id[i - 1];
            shadow_prio[i] = shadow_prio[i - 1];
          end
          shadow_id[pos]   = w.entry_id;
          shadow_prio[pos] = w.entry_priority;
          held++;
        end
      end
      ACT_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_id       = shadow_id[0];
          r.removed_priority = shadow_prio[0];
          close_gap(0);
        end
      end
      ACT_REMOVE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first match in queue order wins
          hit = -1;
          for (int i = 0; i < held; i++) begin
            if (hit < 0 && shadow_id[i] == w.entry_id) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.removed_id       = shadow_id[hit];
            r.removed_priority = shadow_prio[hit];
            close_gap(hit);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_WIDTH'(held);
    return r;
  endfunction

  // result first, then any word taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      owed.delete();
      outstanding <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (owed.size() == 0) begin
          report("unexpected result word", '0, 32'(out_word));
        end else begin
          due = owed.pop_front();
          if (out_word.status !== due.status)
            report("status", 32'(due.status), 32'(out_word.status));
          if (out_word.removed_id !== due.removed_id)
            report("removed_id", 32'(due.removed_id), 32'(out_word.removed_id));
          if (out_word.removed_priority !== due.removed_priority)
            report("removed_priority", 32'(due.removed_priority),
                   32'(out_word.removed_priority));
          if (out_word.occupancy !== due.occupancy)
            report("occupancy", 32'(due.occupancy), 32'(out_word.occupancy));
          case (due.status)
            ST_OK:        ok_seen++;
            ST_EMPTY:     empty_seen++;
            ST_NOT_FOUND: absent_seen++;
            default:      full_seen++;
          endcase
          if (int'(due.occupancy) > peak_held) peak_held = int'(due.occupancy);
        end
      end
      if (start === 1'b1 && busy === 1'b0) owed.push_back(apply_command(in_word));
      outstanding <= owed.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the sorted priority task queue: a directed opening covering
// empty, full, tie and duplicate-id cases, then biased random fill and drain
// traffic with random sender gaps. Checking is done by queue_checker.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int RANDOM_WORDS   = 2000;
  localparam int CALM_WORDS     = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  int mismatches, outstanding, peak_held;
  int ok_seen, empty_seen, absent_seen, full_seen;
  int words_sent = 0;
  int idle_run = 0;

  always #5 clk = ~clk;

  sorted_priority_task_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  queue_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .ok_seen     (ok_seen),
    .empty_seen  (empty_seen),
    .absent_seen (absent_seen),
    .full_seen   (full_seen),
    .peak_held   (peak_held)
  );

  // watchdog: cycles with nothing moving on either channel
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // hold the word with start high until it is taken; start stays high after
  task automatic send(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    words_sent++;
  endtask

  task automatic issue(input action_t a, input logic [ID_WIDTH-1:0] id,
                       input logic [PRIO_WIDTH-1:0] pr);
    in_word_t w;
    w.action         = a;
    w.entry_id       = id;
    w.entry_priority = pr;
    send(w);
  endtask

  // sender gap with start low and junk on the bus
  task automatic idle_gap();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      start   <= 1'b0;
      in_word <= in_word_t'($urandom);
      @(posedge clk);
    end
  endtask

  // random command, leaning towards filling or draining the queue
  function automatic in_word_t make_command(input bit filling);
    in_word_t w;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 3)                         w.action = ACT_NONE;
    else if (roll < (filling ? 70 : 32))  w.action = ACT_INSERT;
    else if (roll < (filling ? 85 : 66))  w.action = ACT_POP;
    else                                  w.action = ACT_REMOVE;
    // small id pool so removes hit and duplicates occur
    case ($urandom_range(3))
      0, 1:    w.entry_id = ID_WIDTH'($urandom_range(15));
      2:       w.entry_id = ID_WIDTH'($urandom);
      default: w.entry_id = $urandom_range(1) ? '1 : '0;
    endcase
    // narrow priority range for plenty of ties
    roll = $urandom_range(9);
    if (roll < 5)      w.entry_priority = PRIO_WIDTH'($urandom_range(3));
    else if (roll < 9) w.entry_priority = PRIO_WIDTH'($urandom);
    else               w.entry_priority = $urandom_range(1) ? '1 : '0;
    return w;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: operations on an empty queue, including the unused code
    issue(ACT_POP, '0, '0);
    issue(ACT_REMOVE, '1, '0);
    issue(ACT_NONE, 16'h1234, '1);
    // fill to capacity with extreme ids, duplicate ids and tied priorities
    for (int k = 0; k < CAPACITY; k++) begin
      case (k % 4)
        0:       issue(ACT_INSERT, (k == 1) ? '1 : ID_WIDTH'(k % 8), '1);
        1:       issue(ACT_INSERT, (k == 1) ? '1 : ID_WIDTH'(k % 8), '0);
        default: issue(ACT_INSERT, ID_WIDTH'(k % 8), 8'h80);
      endcase
    end
    issue(ACT_INSERT, 16'hBEEF, 8'h55);   // rejected, queue full
    issue(ACT_NONE, '0, '0);              // unused code while full
    issue(ACT_REMOVE, 16'hABCD, '0);      // no such id
    issue(ACT_REMOVE, 16'd3, '0);         // duplicate id, first one goes
    issue(ACT_POP, '0, '0);

    // let the block drain completely before the random traffic
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    // random: a calm stretch first, then gaps in about 23 of 100 slots
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= CALM_WORDS && $urandom_range(99) < 23) idle_gap();
      send(make_command(((n / 64) % 2) == 0));
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d ok, %0d empty, %0d id missing, %0d full",
             words_sent, ok_seen, empty_seen, absent_seen, full_seen);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_held, CAPACITY, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_task_queue.sv
bench/queue_checker.sv
bench/testbench.sv
